// ----- hdl/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// shared types of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    // operation selected per item
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

endpackage

// ----- hdl/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// complex add, subtract, multiply and divide on signed fixed point operands
// with saturation, overflow and divide-by-zero flags
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  --------------------------------------
//  operands  in   i_valid / o_stall   i_command, i_left_*, i_right_*
//  results   out  o_valid / i_stall   o_result_*, o_divide_by_zero, o_overflow
//
//  one item per cycle while o_stall is low; most of the pipeline depth is
//  the divider's one-bit-per-stage chain
//  all commands run through the same stages so items leave in order
//  i_rst_n is synchronous and clears only the valid bits and the skid stage
//  a stalled result moves into a one-item skid register; the pipeline (and
//  o_stall) holds only while that skid register is full
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operand channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cau_pkg::t_cmd                 i_command,
    input  logic signed [DATA_WIDTH-1:0]  i_left_real,
    input  logic signed [DATA_WIDTH-1:0]  i_left_imag,
    input  logic signed [DATA_WIDTH-1:0]  i_right_real,
    input  logic signed [DATA_WIDTH-1:0]  i_right_imag,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_result_real,
    output logic signed [DATA_WIDTH-1:0]  o_result_imag,
    output logic                          o_divide_by_zero,
    output logic                          o_overflow
);

    import cau_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;      // product width
    localparam int SW  = PW + 1;      // sum of two products
    localparam int QW  = DW + 1;      // quotient bits kept by the divider
    localparam int NST = QW + 1;      // divider stages incl. its prep stage

    localparam logic signed [DW-1:0] S_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QW-1:0]        LIM_POS = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QW-1:0]        LIM_NEG = {2'b01, {(DW-1){1'b0}}};

    // global advance: the whole pipeline moves unless the skid stage is full
    logic w_en;
    logic r_skid_v;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    // ------------------------------------------------------------------
    // stage 1: operand capture
    // ------------------------------------------------------------------
    logic                 r_v1;
    t_cmd                 r1_cmd;
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= i_command;
            r1_a   <= i_left_real;
            r1_b   <= i_left_imag;
            r1_c   <= i_right_real;
            r1_d   <= i_right_imag;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: six products, the add/sub sums and the zero divisor check
    // ------------------------------------------------------------------
    logic                 r_v2;
    t_cmd                 r2_cmd;
    logic signed [DW:0]   r2_sum_re, r2_sum_im;
    logic signed [PW-1:0] r2_ac, r2_bd, r2_ad, r2_bc, r2_cc, r2_dd;
    logic                 r2_dz;
    logic signed [DW:0]   n_sum_re, n_sum_im;

    always_comb begin
        if (r1_cmd == CMD_SUB) begin
            n_sum_re = (DW+1)'(r1_a) - (DW+1)'(r1_c);
            n_sum_im = (DW+1)'(r1_b) - (DW+1)'(r1_d);
        end else begin
            n_sum_re = (DW+1)'(r1_a) + (DW+1)'(r1_c);
            n_sum_im = (DW+1)'(r1_b) + (DW+1)'(r1_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cmd    <= r1_cmd;
            r2_sum_re <= n_sum_re;
            r2_sum_im <= n_sum_im;
            r2_ac     <= r1_a * r1_c;
            r2_bd     <= r1_b * r1_d;
            r2_ad     <= r1_a * r1_d;
            r2_bc     <= r1_b * r1_c;
            r2_cc     <= r1_c * r1_c;
            r2_dd     <= r1_d * r1_d;
            r2_dz     <= (r1_cmd == CMD_DIV) && (r1_c == '0) && (r1_d == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: exact product sums; multiply and divide numerators differ
    // in the signs of the bd and ad terms
    // ------------------------------------------------------------------
    logic                 r_v3;
    t_cmd                 r3_cmd;
    logic signed [DW:0]   r3_sum_re, r3_sum_im;
    logic signed [SW-1:0] r3_p_re, r3_p_im;
    logic [PW-1:0]        r3_den;
    logic                 r3_dz;
    logic signed [SW-1:0] n_p_re, n_p_im;

    always_comb begin
        if (r2_cmd == CMD_DIV) begin
            n_p_re = SW'(r2_ac) + SW'(r2_bd);
            n_p_im = SW'(r2_bc) - SW'(r2_ad);
        end else begin
            n_p_re = SW'(r2_ac) - SW'(r2_bd);
            n_p_im = SW'(r2_ad) + SW'(r2_bc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_cmd    <= r2_cmd;
            r3_sum_re <= r2_sum_re;
            r3_sum_im <= r2_sum_im;
            r3_p_re   <= n_p_re;
            r3_p_im   <= n_p_im;
            r3_den    <= $unsigned(r2_cc) + $unsigned(r2_dd);
            r3_dz     <= r2_dz;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: add/sub/mul results finished and saturated here; for a
    // divide the numerators go to sign and magnitude
    // ------------------------------------------------------------------
    logic                 r_v4;
    logic                 r4_div, r4_dz, r4_ovf, r4_sre, r4_sim;
    logic signed [DW-1:0] r4_re, r4_im;
    logic [PW-1:0]        r4_mre, r4_mim, r4_den;

    logic signed [SW-1:0] w_sh_re, w_sh_im;
    logic [SW-DW:0]       w_top_re, w_top_im;
    logic                 w_fit_re, w_fit_im;
    logic signed [DW-1:0] n_re4, n_im4;
    logic                 n_ovf4;

    // multiply: arithmetic shift rounds toward minus infinity
    assign w_sh_re  = r3_p_re >>> FRAC_BITS;
    assign w_sh_im  = r3_p_im >>> FRAC_BITS;
    assign w_top_re = w_sh_re[SW-1:DW-1];
    assign w_top_im = w_sh_im[SW-1:DW-1];

    always_comb begin
        case (r3_cmd)
            CMD_MUL: begin
                w_fit_re = (&w_top_re) || !(|w_top_re);
                w_fit_im = (&w_top_im) || !(|w_top_im);
                n_re4    = w_fit_re ? w_sh_re[DW-1:0] : (w_sh_re[SW-1] ? S_MIN : S_MAX);
                n_im4    = w_fit_im ? w_sh_im[DW-1:0] : (w_sh_im[SW-1] ? S_MIN : S_MAX);
            end
            default: begin
                w_fit_re = r3_sum_re[DW] == r3_sum_re[DW-1];
                w_fit_im = r3_sum_im[DW] == r3_sum_im[DW-1];
                n_re4    = w_fit_re ? r3_sum_re[DW-1:0] : (r3_sum_re[DW] ? S_MIN : S_MAX);
                n_im4    = w_fit_im ? r3_sum_im[DW-1:0] : (r3_sum_im[DW] ? S_MIN : S_MAX);
            end
        endcase
        n_ovf4 = !w_fit_re || !w_fit_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_div <= r3_cmd == CMD_DIV;
            r4_dz  <= r3_dz;
            r4_re  <= n_re4;
            r4_im  <= n_im4;
            r4_ovf <= n_ovf4;
            r4_sre <= r3_p_re[SW-1];
            r4_sim <= r3_p_im[SW-1];
            r4_mre <= PW'(r3_p_re[SW-1] ? -r3_p_re : r3_p_re);
            r4_mim <= PW'(r3_p_im[SW-1] ? -r3_p_im : r3_p_im);
            r4_den <= r3_den;
        end
    end

    // ------------------------------------------------------------------
    // divider stages; the finished results of the other commands ride
    // alongside in a sideband line of the same depth
    // ------------------------------------------------------------------
    logic [QW-1:0] w_q_re, w_q_im;
    logic          w_over_re, w_over_im;

    cau_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_re (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (r4_mre),
        .i_den  (r4_den),
        .o_quot (w_q_re),
        .o_over (w_over_re)
    );

    cau_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_im (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (r4_mim),
        .i_den  (r4_den),
        .o_quot (w_q_im),
        .o_over (w_over_im)
    );

    logic [NST-1:0]       r_vd;
    logic                 r_sd_div [0:NST-1];
    logic                 r_sd_dz  [0:NST-1];
    logic                 r_sd_ovf [0:NST-1];
    logic                 r_sd_sre [0:NST-1];
    logic                 r_sd_sim [0:NST-1];
    logic signed [DW-1:0] r_sd_re  [0:NST-1];
    logic signed [DW-1:0] r_sd_im  [0:NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (w_en) begin
            r_vd <= {r_vd[NST-2:0], r_v4};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd_div[0] <= r4_div;
            r_sd_dz[0]  <= r4_dz;
            r_sd_ovf[0] <= r4_ovf;
            r_sd_sre[0] <= r4_sre;
            r_sd_sim[0] <= r4_sim;
            r_sd_re[0]  <= r4_re;
            r_sd_im[0]  <= r4_im;
            for (int k = 1; k < NST; k++) begin
                r_sd_div[k] <= r_sd_div[k-1];
                r_sd_dz[k]  <= r_sd_dz[k-1];
                r_sd_ovf[k] <= r_sd_ovf[k-1];
                r_sd_sre[k] <= r_sd_sre[k-1];
                r_sd_sim[k] <= r_sd_sim[k-1];
                r_sd_re[k]  <= r_sd_re[k-1];
                r_sd_im[k]  <= r_sd_im[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: quotient saturation and sign, zero divisor, selection
    // ------------------------------------------------------------------
    logic                 r_vo;
    logic signed [DW-1:0] r_o_re, r_o_im;
    logic                 r_o_dz, r_o_ovf;

    logic [QW-1:0]        w_lim_re, w_lim_im, w_mag_re, w_mag_im, w_sv_re, w_sv_im;
    logic                 w_sat_re, w_sat_im;
    logic signed [DW-1:0] n_o_re, n_o_im;
    logic                 n_o_dz, n_o_ovf;

    always_comb begin
        // a negative quotient may reach one step further than a positive one
        w_lim_re = r_sd_sre[NST-1] ? LIM_NEG : LIM_POS;
        w_lim_im = r_sd_sim[NST-1] ? LIM_NEG : LIM_POS;
        w_sat_re = w_over_re || (w_q_re > w_lim_re);
        w_sat_im = w_over_im || (w_q_im > w_lim_im);
        w_mag_re = w_sat_re ? w_lim_re : w_q_re;
        w_mag_im = w_sat_im ? w_lim_im : w_q_im;
        w_sv_re  = r_sd_sre[NST-1] ? -w_mag_re : w_mag_re;
        w_sv_im  = r_sd_sim[NST-1] ? -w_mag_im : w_mag_im;

        if (r_sd_dz[NST-1]) begin
            n_o_re  = '0;
            n_o_im  = '0;
            n_o_dz  = 1'b1;
            n_o_ovf = 1'b0;
        end else if (r_sd_div[NST-1]) begin
            n_o_re  = w_sv_re[DW-1:0];
            n_o_im  = w_sv_im[DW-1:0];
            n_o_dz  = 1'b0;
            n_o_ovf = w_sat_re || w_sat_im;
        end else begin
            n_o_re  = r_sd_re[NST-1];
            n_o_im  = r_sd_im[NST-1];
            n_o_dz  = 1'b0;
            n_o_ovf = r_sd_ovf[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= r_vd[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_re  <= n_o_re;
            r_o_im  <= n_o_im;
            r_o_dz  <= n_o_dz;
            r_o_ovf <= n_o_ovf;
        end
    end

    // ------------------------------------------------------------------
    // skid stage: catches the output item when the pipeline moves on while
    // the result channel is stalled
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_k_re, r_k_im;
    logic                 r_k_dz, r_k_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v && !i_stall) begin
            r_skid_v <= 1'b0;
        end else if (w_en && r_vo && i_stall) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vo && i_stall) begin
            r_k_re  <= r_o_re;
            r_k_im  <= r_o_im;
            r_k_dz  <= r_o_dz;
            r_k_ovf <= r_o_ovf;
        end
    end

    assign o_valid          = r_skid_v || r_vo;
    assign o_result_real    = r_skid_v ? r_k_re  : r_o_re;
    assign o_result_imag    = r_skid_v ? r_k_im  : r_o_im;
    assign o_divide_by_zero = r_skid_v ? r_k_dz  : r_o_dz;
    assign o_overflow       = r_skid_v ? r_k_ovf : r_o_ovf;

`ifndef SYNTH
    // zero divisor gives a clean zero result with no overflow
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            (o_result_real == '0) && (o_result_imag == '0) && !o_overflow)
        else $error("divide by zero item with nonzero result or overflow");

    // an overflow item carries at least one saturated part
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            (o_result_real == S_MAX) || (o_result_real == S_MIN) ||
            (o_result_imag == S_MAX) || (o_result_imag == S_MIN))
        else $error("overflow flagged without a saturated part");

    // while the skid stage is full the pipeline holds its output item
    a_skid_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_vo) && $stable(r_o_re) && $stable(r_o_im))
        else $error("pipeline moved while the skid stage was full");

    // the skid stage fills only behind a stalled result
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(i_stall) && $past(r_vo))
        else $error("skid stage filled without a stalled result");
`endif

endmodule

// ----- hdl/cau_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider, one quotient bit per stage; gives
// floor((mag << FRAC_BITS) / den) over DATA_WIDTH+1 bits and a flag when
// the quotient does not fit in that many bits
// ----------------------------------------------------------------------------
module cau_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*DATA_WIDTH-1:0]   i_mag,
    input  logic [2*DATA_WIDTH-1:0]   i_den,
    output logic [DATA_WIDTH:0]       o_quot,
    output logic                      o_over
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int QW = DATA_WIDTH + 1;
    localparam int XW = PW + FRAC_BITS;
    localparam int HW = XW - QW;
    localparam int KW = (HW > PW) ? HW : PW;

    logic [XW-1:0] w_x;
    logic [HW-1:0] w_x_hi;

    logic [PW-1:0] r_rem  [0:QW-1];
    logic [PW-1:0] r_den  [0:QW-1];
    logic [QW-1:0] r_ql   [0:QW];
    logic          r_over [0:QW];

    // scaled numerator; high part must stay below den for a fitting quotient
    assign w_x    = XW'(i_mag) << FRAC_BITS;
    assign w_x_hi = w_x[XW-1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= PW'(w_x_hi);
            r_den[0]  <= i_den;
            r_ql[0]   <= w_x[QW-1:0];
            r_over[0] <= KW'(w_x_hi) >= KW'(i_den);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [PW:0] w_trial;
        logic [PW:0] w_diff;
        logic        w_ge;

        assign w_trial = {r_rem[k-1], r_ql[k-1][QW-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};

        // low numerator bits leave at the top, quotient bits enter at the bottom
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ql[k]   <= {r_ql[k-1][QW-2:0], w_ge};
                r_over[k] <= r_over[k-1];
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quot = r_ql[QW];
    assign o_over = r_over[QW];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the complex arithmetic unit: operand items with
// random gaps go in, every result is compared against a wide-integer
// prediction of add, subtract, multiply and divide with saturation
// ----------------------------------------------------------------------------
module testbench;

    import cau_pkg::*;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LONG_HOLD  = 400;     // cycles of receiver hold-off
    localparam int DRAIN_WAIT = 60;      // beyond the pipeline latency

    localparam logic signed [DATA_WIDTH-1:0] MAX_V = 32'sh7fff_ffff;
    localparam logic signed [DATA_WIDTH-1:0] MIN_V = 32'sh8000_0000;
    localparam logic signed [DATA_WIDTH-1:0] ONE_V = 32'sh0001_0000;
    localparam logic signed [127:0] PART_MAX = 128'sd2147483647;
    localparam logic signed [127:0] PART_MIN = -128'sd2147483648;

    typedef struct {
        t_cmd                         cmd;
        logic signed [DATA_WIDTH-1:0] lr;
        logic signed [DATA_WIDTH-1:0] li;
        logic signed [DATA_WIDTH-1:0] rr;
        logic signed [DATA_WIDTH-1:0] ri;
        int                           gap;    // idle cycles before offering
        bit                           drain;  // wait for all results first
    } t_op_item;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic                         dz;
        logic                         ovf;
    } t_cplx_result;

    // ports; every input is known from time zero
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic                         o_stall;
    t_cmd                         i_command    = CMD_ADD;
    logic signed [DATA_WIDTH-1:0] i_left_real  = '0;
    logic signed [DATA_WIDTH-1:0] i_left_imag  = '0;
    logic signed [DATA_WIDTH-1:0] i_right_real = '0;
    logic signed [DATA_WIDTH-1:0] i_right_imag = '0;
    logic                         o_valid;
    logic                         i_stall      = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_result_real;
    logic signed [DATA_WIDTH-1:0] o_result_imag;
    logic                         o_divide_by_zero;
    logic                         o_overflow;

    t_op_item     pending_ops[$];
    t_cplx_result expected_results[$];

    int ops_total    = 0;
    int ops_accepted = 0;
    int res_count    = 0;
    int fail_count   = 0;
    int cmd_count[4] = '{0, 0, 0, 0};
    int sat_seen     = 0;
    int dz_seen      = 0;
    int stall_run    = 0;
    int stall_max    = 0;
    bit op_fire      = 1'b0;   // operand item taken at the last rising edge
    bit res_fire     = 1'b0;   // result item taken at the last rising edge

    complex_arithmetic_unit #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_left_real      (i_left_real),
        .i_left_imag      (i_left_imag),
        .i_right_real     (i_right_real),
        .i_right_imag     (i_right_imag),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_real    (o_result_real),
        .o_result_imag    (o_result_imag),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflow       (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // clip a wide part to the signed data range, flag when clipped
    function automatic logic signed [DATA_WIDTH-1:0] clamp_part(
        input  logic signed [127:0] v,
        output logic                sat
    );
        sat = 1'b1;
        if (v > PART_MAX) return MAX_V;
        if (v < PART_MIN) return MIN_V;
        sat = 1'b0;
        return v[DATA_WIDTH-1:0];
    endfunction

    // all products and sums are exact in 128 bits: the largest divide
    // numerator is 2^63 shifted by the fraction bits
    function automatic t_cplx_result predict_result(
        input t_cmd                         cmd,
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b,
        input logic signed [DATA_WIDTH-1:0] c,
        input logic signed [DATA_WIDTH-1:0] d
    );
        logic signed [127:0] wa, wb, wc, wd, re_w, im_w, den;
        logic                re_sat, im_sat;
        t_cplx_result        r;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        r.dz = 1'b0;
        case (cmd)
            CMD_ADD: begin
                re_w = wa + wc;
                im_w = wb + wd;
            end
            CMD_SUB: begin
                re_w = wa - wc;
                im_w = wb - wd;
            end
            CMD_MUL: begin
                // arithmetic shift rounds toward minus infinity
                re_w = (wa * wc - wb * wd) >>> FRAC_BITS;
                im_w = (wa * wd + wb * wc) >>> FRAC_BITS;
            end
            default: begin
                den = wc * wc + wd * wd;
                if (den == 0) begin
                    re_w = 0;
                    im_w = 0;
                    r.dz = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    re_w = ((wa * wc + wb * wd) <<< FRAC_BITS) / den;
                    im_w = ((wb * wc - wa * wd) <<< FRAC_BITS) / den;
                end
            end
        endcase
        r.re  = clamp_part(re_w, re_sat);
        r.im  = clamp_part(im_w, im_sat);
        r.ovf = re_sat | im_sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_op(
        input t_cmd                         cmd,
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b,
        input logic signed [DATA_WIDTH-1:0] c,
        input logic signed [DATA_WIDTH-1:0] d,
        input int                           gap,
        input bit                           drain
    );
        t_op_item op;
        op.cmd   = cmd;
        op.lr    = a;
        op.li    = b;
        op.rr    = c;
        op.ri    = d;
        op.gap   = gap;
        op.drain = drain;
        pending_ops.push_back(op);
        ops_total++;
    endtask

    // mix of corner values, modest values that rarely saturate, and full range
    function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0: return '0;
                    1: return 32'sd1;
                    2: return -32'sd1;
                    3: return MAX_V;
                    4: return MIN_V;
                    5: return ONE_V;
                    default: return -ONE_V;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            4: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // operand driver: changes inputs at the falling edge only
    // ------------------------------------------------------------------------
    int       wait_cnt = 0;
    t_op_item cur_op;

    always @(negedge i_clk) begin
        // hold a stalled item; otherwise move on to the next one
        if (i_rst_n && !(i_valid && !op_fire)) begin
            if (pending_ops.size() != 0 && wait_cnt >= pending_ops[0].gap &&
                !(pending_ops[0].drain && expected_results.size() != 0)) begin
                cur_op       = pending_ops.pop_front();
                i_command    <= cur_op.cmd;
                i_left_real  <= cur_op.lr;
                i_left_imag  <= cur_op.li;
                i_right_real <= cur_op.rr;
                i_right_imag <= cur_op.ri;
                i_valid      <= 1'b1;
                wait_cnt     = 0;
            end else begin
                i_valid <= 1'b0;
                if (pending_ops.size() != 0 && wait_cnt < pending_ops[0].gap)
                    wait_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: per-item stall draw, style changes every 100 results,
    // plus two long hold-offs that back the pipeline up into o_stall
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_fire) begin
                if (res_count == 300 || res_count == 900) begin
                    hold_left = LONG_HOLD;
                end else begin
                    case ((res_count / 100) % 3)
                        0: hold_left = $urandom_range(0, 9);
                        1: hold_left = 0;
                        default: hold_left = ($urandom_range(0, 5) == 0) ?
                                             $urandom_range(1, 9) : 0;
                    endcase
                end
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------------
    t_cplx_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            op_fire  <= i_valid && !o_stall;
            res_fire <= o_valid && !i_stall;

            // results first, so an item taken this edge never matches
            if (o_valid && !i_stall) begin
                res_count++;
                if (o_overflow) sat_seen++;
                if (o_divide_by_zero) dz_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result item with nothing expected: real %0d imag %0d",
                           o_result_real, o_result_imag);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result_real !== want.re) begin
                        fail_count++;
                        $error("result_real: expected %0d, got %0d",
                               want.re, o_result_real);
                    end
                    if (o_result_imag !== want.im) begin
                        fail_count++;
                        $error("result_imag: expected %0d, got %0d",
                               want.im, o_result_imag);
                    end
                    if (o_divide_by_zero !== want.dz) begin
                        fail_count++;
                        $error("divide_by_zero: expected %0b, got %0b",
                               want.dz, o_divide_by_zero);
                    end
                    if (o_overflow !== want.ovf) begin
                        fail_count++;
                        $error("overflow: expected %0b, got %0b",
                               want.ovf, o_overflow);
                    end
                end
            end

            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_result(i_command, i_left_real,
                    i_left_imag, i_right_real, i_right_imag));
                ops_accepted++;
                cmd_count[i_command]++;
            end

            // longest stretch of back-pressure on the operand side
            if (i_valid && o_stall) begin
                stall_run++;
                if (stall_run > stall_max) stall_max = stall_run;
            end else begin
                stall_run = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int   gap_style;
        t_cmd cmd;
        logic signed [DATA_WIDTH-1:0] a, b, c, d;

        // directed: saturation at both ends, rounding direction, zero divisor
        queue_op(CMD_ADD, MAX_V, MAX_V, MAX_V, MAX_V, 0, 1'b0);
        queue_op(CMD_ADD, MIN_V, MIN_V, MIN_V, MIN_V, 0, 1'b0);
        queue_op(CMD_ADD, '0, '0, '0, '0, 0, 1'b0);
        queue_op(CMD_ADD, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 0, 1'b0);
        queue_op(CMD_SUB, MIN_V, MAX_V, MAX_V, MIN_V, 0, 1'b0);
        queue_op(CMD_SUB, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 0, 1'b0);
        queue_op(CMD_SUB, '0, '0, MIN_V, MIN_V, 0, 1'b0);
        queue_op(CMD_MUL, ONE_V, ONE_V, ONE_V, ONE_V, 0, 1'b0);
        queue_op(CMD_MUL, MIN_V, MIN_V, MIN_V, MIN_V, 0, 1'b0);
        queue_op(CMD_MUL, -32'sd1, '0, 32'sd1, '0, 0, 1'b0);    // floors to -1
        queue_op(CMD_MUL, 32'sd1, '0, 32'sd1, '0, 0, 1'b0);     // floors to 0
        queue_op(CMD_MUL, MAX_V, MIN_V, MAX_V, MAX_V, 0, 1'b0);
        queue_op(CMD_DIV, ONE_V, ONE_V, '0, '0, 0, 1'b0);       // zero divisor
        queue_op(CMD_DIV, '0, '0, '0, '0, 0, 1'b0);
        queue_op(CMD_DIV, ONE_V, '0, ONE_V, '0, 0, 1'b0);
        queue_op(CMD_DIV, MIN_V, MAX_V, 32'sd1, '0, 0, 1'b0);   // huge quotient
        queue_op(CMD_DIV, 32'sd1, '0, MAX_V, MAX_V, 0, 1'b0);   // tiny quotient
        queue_op(CMD_DIV, -ONE_V, ONE_V, 3 * ONE_V, '0, 0, 1'b0); // truncation
        queue_op(CMD_DIV, MIN_V, MIN_V, MIN_V, MIN_V, 0, 1'b0);
        queue_op(CMD_DIV, MAX_V, -32'sd1, -32'sd1, '0, 0, 1'b0);
        queue_op(CMD_DIV, MAX_V, MIN_V, '0, MIN_V, 3, 1'b0);

        // random: sender gap style changes every 50 items, with a full
        // drain before every 250th item
        gap_style = 0;
        for (int n = 0; n < 1250; n++) begin
            if (n % 50 == 0) gap_style = $urandom_range(0, 2);
            cmd = t_cmd'($urandom_range(0, 3));
            a = pick_operand();
            b = pick_operand();
            c = pick_operand();
            d = pick_operand();
            if (cmd == CMD_DIV && $urandom_range(0, 11) == 0) begin
                c = '0;
                d = '0;
            end
            case (gap_style)
                0: queue_op(cmd, a, b, c, d, 0, n % 250 == 249);
                1: queue_op(cmd, a, b, c, d, $urandom_range(0, 9), n % 250 == 249);
                default: queue_op(cmd, a, b, c, d,
                                  ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0,
                                  n % 250 == 249);
            endcase
        end

        // single reset at the start
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted != ops_total) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        // any stray result would show up within the pipeline latency
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("ran %0d items: %0d add, %0d sub, %0d mul, %0d div",
                 ops_accepted, cmd_count[CMD_ADD], cmd_count[CMD_SUB],
                 cmd_count[CMD_MUL], cmd_count[CMD_DIV]);
        $display("%0d saturated results, %0d zero divisors, input held off up to %0d cycles",
                 sat_seen, dz_seen, stall_max);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
